FILE: rtl/escaped_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// escaped_frame_decoder_assert
// Assertion macros shared by the escaped frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DECODER_ASSERT_SVH
`define ESCAPED_FRAME_DECODER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define EFD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define EFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Types and constants shared by the escaped frame decoder modules.
// ----------------------------------------------------------------------------
package efd_pkg;

   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_CODE = 4'd3;

   localparam logic [7:0] RESET_ESCAPE_CODE = 8'd16;
   localparam logic [7:0] RESET_START_CODE = 8'd2;
   localparam logic [7:0] RESET_END_CODE = 8'd3;
   localparam logic [7:0] RESET_TYPE_CODE = 8'd147;

   // The header holds twelve bytes; the count of the last one.
   localparam logic [3:0] HEADER_LAST = 4'd11;

   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_DONE = 3'd1;
   localparam logic [2:0] KIND_PREMATURE_END = 3'd2;
   localparam logic [2:0] KIND_BAD_ESCAPE = 3'd3;
   localparam logic [2:0] KIND_RESTART = 3'd4;

   localparam int unsigned RSP_DATA_W = 120;
   localparam int unsigned RSP_USER_W = 3;

   typedef struct packed {
      logic [7:0] escape_code;
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] message_type_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  priority_res;
      logic [23:0] pgn;
      logic [7:0]  destination;
      logic [7:0]  source;
      logic [31:0] time_stamp;
      logic [7:0]  length_field;
      logic [7:0]  data_length;
      logic        checksum_ok;
   } result_type;

endpackage

FILE: rtl/efd_core.sv
// ----------------------------------------------------------------------------
// efd_core
// Frame state machine: hunt, header capture, payload un-stuffing, checksum.
// ----------------------------------------------------------------------------
module efd_core (
   input  logic               clock,
   input  logic               reset,
   input  efd_pkg::cfg_type    cfg,
   input  logic               fire,
   input  logic [7:0]         rx_byte,
   output logic               res_valid,
   output efd_pkg::result_type res
);
   import efd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT_ESC   = 3'd0,
      PH_HUNT_START = 3'd1,
      PH_HUNT_TYPE  = 3'd2,
      PH_HEADER     = 3'd3,
      PH_PAYLOAD    = 3'd4,
      PH_CHECK      = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic        esc_pend_ff, esc_pend_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  priority_ff, priority_in;
   logic [23:0] pgn_ff, pgn_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  source_ff, source_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [7:0]  data_len_ff, data_len_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [7:0]  sum_ff, sum_in;

   logic [7:0]  bytes_inc;
   logic        emit;

   assign bytes_inc = bytes_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      esc_pend_in  = esc_pend_ff;
      length_in    = length_ff;
      priority_in  = priority_ff;
      pgn_in       = pgn_ff;
      dest_in      = dest_ff;
      source_in    = source_ff;
      stamp_in     = stamp_ff;
      data_len_in  = data_len_ff;
      bytes_in     = bytes_ff;
      sum_in       = sum_ff;
      emit         = 1'b0;

      res_valid         = 1'b0;
      res.result_kind   = KIND_PAYLOAD;
      res.payload_byte  = 8'd0;
      res.payload_index = bytes_ff;
      res.priority_res  = priority_ff;
      res.pgn           = pgn_ff;
      res.destination   = dest_ff;
      res.source        = source_ff;
      res.time_stamp    = stamp_ff;
      res.length_field  = length_ff;
      res.data_length   = data_len_ff;
      res.checksum_ok   = 1'b0;

      if (fire) begin
         unique case (phase_ff)
            PH_HUNT_START: begin
               priority if (rx_byte == cfg.start_code) phase_in = PH_HUNT_TYPE;
               else if (rx_byte == cfg.escape_code) phase_in = PH_HUNT_START;
               else phase_in = PH_HUNT_ESC;
            end
            PH_HUNT_TYPE: begin
               priority if (rx_byte == cfg.message_type_code) begin
                  phase_in     = PH_HEADER;
                  hdr_count_in = 4'd0;
                  esc_pend_in  = 1'b0;
                  bytes_in     = 8'd0;
                  sum_in       = cfg.message_type_code;
               end else if (rx_byte == cfg.escape_code) begin
                  phase_in = PH_HUNT_START;
               end else begin
                  phase_in = PH_HUNT_ESC;
               end
            end
            PH_HEADER: begin
               unique case (hdr_count_ff)
                  4'd0:    length_in = rx_byte;
                  4'd1:    priority_in = rx_byte;
                  4'd2:    pgn_in[7:0] = rx_byte;
                  4'd3:    pgn_in[15:8] = rx_byte;
                  4'd4:    pgn_in[23:16] = rx_byte;
                  4'd5:    dest_in = rx_byte;
                  4'd6:    source_in = rx_byte;
                  4'd7:    stamp_in[7:0] = rx_byte;
                  4'd8:    stamp_in[15:8] = rx_byte;
                  4'd9:    stamp_in[23:16] = rx_byte;
                  4'd10:   stamp_in[31:24] = rx_byte;
                  default: data_len_in = rx_byte;
               endcase
               sum_in = sum_ff + rx_byte;
               if (hdr_count_ff >= HEADER_LAST) begin
                  hdr_count_in = 4'd0;
                  bytes_in     = 8'd0;
                  esc_pend_in  = 1'b0;
                  // The last header byte is the data length itself.
                  phase_in = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end else begin
                  hdr_count_in = hdr_count_ff + 4'd1;
               end
            end
            PH_PAYLOAD: begin
               if (!esc_pend_ff) begin
                  if (rx_byte == cfg.escape_code) esc_pend_in = 1'b1;
                  else emit = 1'b1;
               end else begin
                  esc_pend_in = 1'b0;
                  priority if (rx_byte == cfg.escape_code) begin
                     emit = 1'b1;
                  end else if (rx_byte == cfg.end_code) begin
                     phase_in        = PH_HUNT_ESC;
                     res_valid       = 1'b1;
                     res.result_kind = KIND_PREMATURE_END;
                  end else if (rx_byte == cfg.start_code) begin
                     phase_in        = PH_HUNT_TYPE;
                     res_valid       = 1'b1;
                     res.result_kind = KIND_RESTART;
                  end else begin
                     phase_in        = PH_HUNT_ESC;
                     res_valid       = 1'b1;
                     res.result_kind = KIND_BAD_ESCAPE;
                  end
               end
            end
            PH_CHECK: begin
               phase_in        = PH_HUNT_ESC;
               res_valid       = 1'b1;
               res.result_kind = KIND_DONE;
               res.checksum_ok = (rx_byte == (8'd0 - sum_ff));
            end
            default: begin
               phase_in = (rx_byte == cfg.escape_code) ? PH_HUNT_START : PH_HUNT_ESC;
            end
         endcase

         if (emit) begin
            res_valid        = 1'b1;
            res.payload_byte = rx_byte;
            sum_in           = sum_ff + rx_byte;
            bytes_in         = bytes_inc;
            if (bytes_inc == data_len_ff) phase_in = PH_CHECK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT_ESC;
         hdr_count_ff <= 4'd0;
         esc_pend_ff  <= 1'b0;
         length_ff    <= 8'd0;
         priority_ff  <= 8'd0;
         pgn_ff       <= 24'd0;
         dest_ff      <= 8'd0;
         source_ff    <= 8'd0;
         stamp_ff     <= 32'd0;
         data_len_ff  <= 8'd0;
         bytes_ff     <= 8'd0;
         sum_ff       <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         esc_pend_ff  <= esc_pend_in;
         length_ff    <= length_in;
         priority_ff  <= priority_in;
         pgn_ff       <= pgn_in;
         dest_ff      <= dest_in;
         source_ff    <= source_in;
         stamp_ff     <= stamp_in;
         data_len_ff  <= data_len_in;
         bytes_ff     <= bytes_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

FILE: rtl/efd_out_buf.sv
// ----------------------------------------------------------------------------
// efd_out_buf
// Result register with a skid entry, so the decoder keeps taking bytes
// while a finished result waits for the consumer.
// ----------------------------------------------------------------------------
module efd_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  efd_pkg::result_type push_data,
   output logic               ready,
   output logic               out_valid,
   input  logic               out_ready,
   output efd_pkg::result_type out_data
);
   import efd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop       = out_valid_ff && out_ready;
   assign ready     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: rtl/escaped_frame_decoder.sv
// ----------------------------------------------------------------------------
// escaped_frame_decoder
// Decodes an escape-stuffed frame stream one received byte at a time.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// req_*     in         one received byte per transaction
// rsp_*     out        payload byte, message done or error report
// csr_*     in         write-only code registers
//
// One byte per cycle is sustained while the skid entry is empty; a byte's
// result passes the input register and the frame state machine and is
// registered in the result register or skid entry. Reset is synchronous and
// restores the default codes and the hunt. A stalled result port fills the
// result register and its skid entry; once the input register also holds a
// byte, req_tready drops until the consumer takes a result.
// ----------------------------------------------------------------------------
`include "escaped_frame_decoder_assert.svh"

module escaped_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] priority_res,
   // [47:24] pgn, [55:48] destination, [63:56] source, [95:64] time_stamp,
   // [103:96] length_field, [111:104] data_length, [112] checksum_ok
   output logic [efd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [efd_pkg::RSP_USER_W-1:0] rsp_tuser,  // [2:0] result_kind
   input  logic                          csr_we,
   input  logic [efd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import efd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       buf_ready;
   logic       core_fire;
   logic       res_valid;
   result_type res;
   result_type rsp;
   logic       rsp_done;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ESCAPE_CODE: cfg_in.escape_code = csr_wdata;
            CSR_START_CODE:  cfg_in.start_code = csr_wdata;
            CSR_END_CODE:    cfg_in.end_code = csr_wdata;
            CSR_TYPE_CODE:   cfg_in.message_type_code = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign core_fire  = in_valid_ff && buf_ready;
   assign req_tready = !in_valid_ff || buf_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (core_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_code       <= RESET_ESCAPE_CODE;
         cfg_ff.start_code        <= RESET_START_CODE;
         cfg_ff.end_code          <= RESET_END_CODE;
         cfg_ff.message_type_code <= RESET_TYPE_CODE;
         in_valid_ff              <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   efd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (core_fire),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   efd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .ready     (buf_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tuser = rsp.result_kind;
   assign rsp_tdata = {7'd0, rsp.checksum_ok, rsp.data_length, rsp.length_field,
                       rsp.time_stamp, rsp.source, rsp.destination, rsp.pgn,
                       rsp.priority_res, rsp.payload_index, rsp.payload_byte};
   assign rsp_done  = (rsp.result_kind == KIND_DONE);

   // A good checksum is only ever reported with a message-done result.
   `EFD_ASSERT_SAME(a_ok_done, rsp_tvalid && rsp.checksum_ok, rsp_done, "checksum_ok off done")

   // An accepted byte must be waiting in the input register next cycle.
   `EFD_ASSERT_NEXT(a_in_captured, req_tvalid && req_tready, in_valid_ff, "accepted byte lost")

   // A byte in the input register that is not decoded stays put.
   `EFD_ASSERT_NEXT(a_in_held, in_valid_ff && !core_fire, in_valid_ff, "byte dropped")
   `EFD_ASSERT_NEXT(a_byte_held, in_valid_ff && !core_fire, $stable(in_byte_ff), "byte changed")

endmodule
